@@ rtl/cht_pkg.sv @@
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants of the chained hash table engine.
// ----------------------------------------------------------------------------
package cht_pkg;

	localparam int BUCKETS  = 1024;
	localparam int POOL     = 1024;
	localparam int KEY_BITS = 64;
	localparam int LISTS    = 32;

	localparam int IDX_W  = $clog2(POOL);
	localparam int PTR_W  = IDX_W + 1;
	localparam int BKT_W  = $clog2(BUCKETS);
	localparam int LIST_W = (LISTS > 1) ? $clog2(LISTS) : 1;
	localparam int CLR_N  = (BUCKETS > POOL) ? BUCKETS : POOL;
	localparam int CLR_W  = $clog2(CLR_N) + 1;
	localparam int CNT_W  = $clog2(POOL + 1);

	typedef logic [PTR_W-1:0] ptr_t;
	localparam ptr_t NIL = ptr_t'(POOL);

	localparam logic [1:0] OP_FIND      = 2'd0;
	localparam logic [1:0] OP_ENTER     = 2'd1;
	localparam logic [1:0] OP_REMOVE    = 2'd2;
	localparam logic [1:0] OP_ENTER_ALT = 2'd3;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	localparam logic [1:0] CFG_BKT_LIMIT   = 2'd0;
	localparam logic [1:0] CFG_FOLD_LO     = 2'd1;
	localparam logic [1:0] CFG_FOLD_HI     = 2'd2;
	localparam logic [1:0] CFG_PARTITIONED = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] hash_value;
		logic [63:0] lookup_key;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [9:0]  entry;
		logic [1:0]  status;
		logic        load_exceeded;
	} rsp_t;

	typedef struct packed {
		logic [9:0]  bkt_limit;
		logic [9:0]  fold_lo;
		logic [10:0] fold_hi;
		logic        partitioned;
	} cfg_t;

	typedef struct packed {
		logic [BKT_W-1:0]    bkt_raddr;
		logic                bkt_we;
		logic [BKT_W-1:0]    bkt_waddr;
		ptr_t                bkt_wdata;
		logic [IDX_W-1:0]    lnk_raddr;
		logic                lnk_we;
		logic [IDX_W-1:0]    lnk_waddr;
		ptr_t                lnk_wdata;
		logic                dat_we;
		logic [IDX_W-1:0]    dat_waddr;
		logic [31:0]         dat_whash;
		logic [KEY_BITS-1:0] dat_wkey;
	} store_req_t;

	typedef struct packed {
		ptr_t                bkt_rdata;
		ptr_t                lnk_rdata;
		logic [31:0]         dat_rhash;
		logic [KEY_BITS-1:0] dat_rkey;
	} store_rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HEAD,
		S_WALK,
		S_DECIDE,
		S_SCAN,
		S_POP,
		S_POP2,
		S_UNLINK,
		S_REL,
		S_DONE
	} state_t;

endpackage

@@ rtl/cht_store.sv @@
// ----------------------------------------------------------------------------
// cht_store
// Bucket heads, entry links and entry hash/key memories, with the
// initialization sweep after reset.
// ----------------------------------------------------------------------------
module cht_store (
	input  logic                clk,
	input  logic                arst_n,
	input  cht_pkg::store_req_t req,
	output cht_pkg::store_rsp_t rsp,
	output logic                busy
);
	import cht_pkg::*;

	ptr_t                bkt_mem [BUCKETS];
	ptr_t                lnk_mem [POOL];
	logic [31:0]         hash_mem [POOL];
	logic [KEY_BITS-1:0] key_mem [POOL];

	logic [CLR_W-1:0] clr_q;
	logic             bkt_we, lnk_we;
	logic [BKT_W-1:0] bkt_wa;
	logic [IDX_W-1:0] lnk_wa;
	ptr_t             bkt_wd, lnk_wd;

	assign busy = (clr_q < CLR_W'(CLR_N));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_comb begin
		if (busy) begin
			bkt_we = (clr_q < CLR_W'(BUCKETS));
			bkt_wa = clr_q[BKT_W-1:0];
			bkt_wd = NIL;
			lnk_we = (clr_q < CLR_W'(POOL));
			lnk_wa = clr_q[IDX_W-1:0];
			lnk_wd = (clr_q == '0) ? NIL : ptr_t'(clr_q - 1'b1);
		end else begin
			bkt_we = req.bkt_we;
			bkt_wa = req.bkt_waddr;
			bkt_wd = req.bkt_wdata;
			lnk_we = req.lnk_we;
			lnk_wa = req.lnk_waddr;
			lnk_wd = req.lnk_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (bkt_we) begin
			bkt_mem[bkt_wa] <= bkt_wd;
		end
		rsp.bkt_rdata <= bkt_mem[req.bkt_raddr];
	end

	always_ff @(posedge clk) begin
		if (lnk_we) begin
			lnk_mem[lnk_wa] <= lnk_wd;
		end
		rsp.lnk_rdata <= lnk_mem[req.lnk_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.dat_we && !busy) begin
			hash_mem[req.dat_waddr] <= req.dat_whash;
			key_mem[req.dat_waddr]  <= req.dat_wkey;
		end
		rsp.dat_rhash <= hash_mem[req.lnk_raddr];
		rsp.dat_rkey  <= key_mem[req.lnk_raddr];
	end

endmodule

@@ rtl/cht_seq.sv @@
// ----------------------------------------------------------------------------
// cht_seq
// Request sequencer: chain walk, free-list pop and push, live counts.
// ----------------------------------------------------------------------------
module cht_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  cht_pkg::cfg_t       cfg,
	input  logic                busy,
	input  logic                in_valid,
	output logic                in_ready,
	input  cht_pkg::req_t       in_data,
	input  logic                out_free,
	output logic                done,
	output cht_pkg::rsp_t       result,
	output cht_pkg::store_req_t sreq,
	input  cht_pkg::store_rsp_t srsp
);
	import cht_pkg::*;

	state_t state_q, state_nx;

	logic [1:0]          op_q;
	logic [31:0]         hash_q;
	logic [KEY_BITS-1:0] key_q;
	logic [BKT_W-1:0]    bkt_q;
	logic [LIST_W-1:0]   list_q, sl_q, k_q;
	logic                load_q, part_q;
	ptr_t                cur_q, prev_q, link_q, e_q;
	logic [CNT_W-1:0]    steps_q;
	logic                found_q;
	logic [9:0]          entry_q;
	logic [1:0]          status_q;
	ptr_t                free_head_q [LISTS];
	logic [CNT_W-1:0]    live_q [LISTS];

	logic [10:0]       b_full;
	logic [BKT_W-1:0]  in_bkt;
	logic              is_enter, match, accept, walk_end;
	ptr_t              fh;
	logic [CNT_W-1:0]  steps_nx;

	always_comb begin
		b_full = in_data.hash_value[10:0] & cfg.fold_hi;
		if (b_full > {1'b0, cfg.bkt_limit}) begin
			b_full = b_full & {1'b0, cfg.fold_lo};
		end
		in_bkt = b_full[BKT_W-1:0];
	end

	assign is_enter = (op_q == OP_ENTER) || (op_q == OP_ENTER_ALT);
	assign match    = (srsp.dat_rhash == hash_q) && (srsp.dat_rkey == key_q);
	assign accept   = in_valid && in_ready;
	assign fh       = free_head_q[sl_q];
	assign steps_nx = steps_q + 1'b1;
	assign walk_end = (srsp.lnk_rdata == NIL) || (steps_nx >= CNT_W'(POOL));

	assign result = '{found: found_q, entry: entry_q, status: status_q,
		load_exceeded: load_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		in_ready = 1'b0;
		done     = 1'b0;
		sreq     = '0;
		sreq.bkt_raddr = in_bkt;
		sreq.lnk_raddr = cur_q[IDX_W-1:0];
		sreq.dat_whash = hash_q;
		sreq.dat_wkey  = key_q;
		unique case (state_q)
			S_CLEAR: begin
				if (!busy) state_nx = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_nx = S_HEAD;
			end
			S_HEAD: begin
				sreq.lnk_raddr = srsp.bkt_rdata[IDX_W-1:0];
				state_nx = (srsp.bkt_rdata == NIL) ? S_DECIDE : S_WALK;
			end
			S_WALK: begin
				sreq.lnk_raddr = srsp.lnk_rdata[IDX_W-1:0];
				if (match || walk_end) state_nx = S_DECIDE;
			end
			S_DECIDE: begin
				if (op_q == OP_REMOVE && found_q) state_nx = S_UNLINK;
				else if (is_enter && !found_q) state_nx = S_SCAN;
				else state_nx = S_DONE;
			end
			S_SCAN: begin
				sreq.lnk_raddr = fh[IDX_W-1:0];
				if (fh != NIL) state_nx = S_POP;
				else if (!(part_q && k_q != LIST_W'(LISTS - 1))) state_nx = S_DONE;
			end
			S_POP: begin
				sreq.dat_we    = 1'b1;
				sreq.dat_waddr = e_q[IDX_W-1:0];
				if (prev_q == NIL) begin
					sreq.bkt_we    = 1'b1;
					sreq.bkt_waddr = bkt_q;
					sreq.bkt_wdata = e_q;
				end else begin
					sreq.lnk_we    = 1'b1;
					sreq.lnk_waddr = prev_q[IDX_W-1:0];
					sreq.lnk_wdata = e_q;
				end
				state_nx = S_POP2;
			end
			S_POP2: begin
				sreq.lnk_we    = 1'b1;
				sreq.lnk_waddr = e_q[IDX_W-1:0];
				sreq.lnk_wdata = NIL;
				state_nx = S_DONE;
			end
			S_UNLINK: begin
				if (prev_q == NIL) begin
					sreq.bkt_we    = 1'b1;
					sreq.bkt_waddr = bkt_q;
					sreq.bkt_wdata = link_q;
				end else begin
					sreq.lnk_we    = 1'b1;
					sreq.lnk_waddr = prev_q[IDX_W-1:0];
					sreq.lnk_wdata = link_q;
				end
				state_nx = S_REL;
			end
			S_REL: begin
				sreq.lnk_we    = 1'b1;
				sreq.lnk_waddr = cur_q[IDX_W-1:0];
				sreq.lnk_wdata = free_head_q[list_q];
				state_nx = S_DONE;
			end
			S_DONE: begin
				done = out_free;
				if (out_free) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q   <= in_data.op;
					hash_q <= in_data.hash_value;
					key_q  <= in_data.lookup_key[KEY_BITS-1:0];
					bkt_q  <= in_bkt;
					part_q <= cfg.partitioned;
					list_q <= cfg.partitioned ? in_data.hash_value[LIST_W-1:0] : '0;
					load_q <= (in_data.op == OP_ENTER || in_data.op == OP_ENTER_ALT)
						&& !cfg.partitioned
						&& (live_q[0] > CNT_W'(cfg.bkt_limit));
				end
			end
			S_HEAD: begin
				cur_q   <= srsp.bkt_rdata;
				prev_q  <= NIL;
				steps_q <= '0;
				found_q <= 1'b0;
			end
			S_WALK: begin
				if (match) begin
					found_q <= 1'b1;
					link_q  <= srsp.lnk_rdata;
				end else begin
					prev_q  <= cur_q;
					cur_q   <= srsp.lnk_rdata;
					steps_q <= steps_nx;
				end
			end
			S_DECIDE: begin
				sl_q     <= list_q;
				k_q      <= '0;
				entry_q  <= found_q ? cur_q[9:0] : 10'd0;
				status_q <= (found_q || is_enter) ? ST_DONE : ST_ABSENT;
			end
			S_SCAN: begin
				e_q  <= fh;
				sl_q <= (fh != NIL) ? sl_q : sl_q + 1'b1;
				k_q  <= k_q + 1'b1;
				if (fh == NIL && !(part_q && k_q != LIST_W'(LISTS - 1))) begin
					status_q <= ST_FULL;
				end
			end
			S_POP2: begin
				entry_q <= e_q[9:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LISTS; i++) begin
				free_head_q[i] <= NIL;
				live_q[i]      <= '0;
			end
			free_head_q[0] <= ptr_t'(POOL - 1);
		end else begin
			if (state_q == S_POP) begin
				free_head_q[sl_q] <= srsp.lnk_rdata;
				if (live_q[list_q] < CNT_W'(POOL)) live_q[list_q] <= live_q[list_q] + 1'b1;
			end
			if (state_q == S_UNLINK && live_q[list_q] != '0) begin
				live_q[list_q] <= live_q[list_q] - 1'b1;
			end
			if (state_q == S_REL) begin
				free_head_q[list_q] <= cur_q;
			end
		end
	end

endmodule

@@ rtl/chained_hash_table_engine_unit.sv @@
// ----------------------------------------------------------------------------
// chained_hash_table_engine_unit
// Hash table over a fixed entry pool with chained buckets and free lists.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------
//  request  | in_valid / in_ready   | in_data   (op, hash, key)
//  result   | out_valid / out_ready | out_data  (found, entry, status, load)
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A request reads its bucket head, walks the chain one entry per link memory
// read and then decides; a remove that hits unlinks and releases the entry,
// and an enter of a new key scans the free lists and pops a free entry.
// After reset the memories are initialized; no request is taken until that
// is done. A waiting result holds the next request in its final state only;
// the next request is taken while the result waits.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cht_pkg::req_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output cht_pkg::rsp_t  out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [10:0]    cfg_data
);
	import cht_pkg::*;

	cfg_t       cfg_q;
	store_req_t sreq;
	store_rsp_t srsp;
	logic       busy, done, out_free;
	rsp_t       result;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{bkt_limit: 10'd1023, fold_lo: 10'd1023,
				fold_hi: 11'd2047, partitioned: 1'b0};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BKT_LIMIT:   cfg_q.bkt_limit   <= cfg_data[9:0];
				CFG_FOLD_LO:     cfg_q.fold_lo     <= cfg_data[9:0];
				CFG_FOLD_HI:     cfg_q.fold_hi     <= cfg_data;
				CFG_PARTITIONED: cfg_q.partitioned <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (done) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) out_data <= result;
	end

	cht_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.rsp    (srsp),
		.busy   (busy)
	);

	cht_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.busy     (busy),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_free (out_free),
		.done     (done),
		.result   (result),
		.sreq     (sreq),
		.srsp     (srsp)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.status == ST_FULL && out_data.found))
		else $error("pool exhausted on a present key");

	a_absent_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_ABSENT |-> !out_data.load_exceeded)
		else $error("load hint on find or remove");

	a_no_accept_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready)
		else $error("request taken during initialization");

endmodule
